### src/rpfb_pkg.sv
package rpfb_pkg;

    // strip geometry
    localparam int MAX_PIXELS = 32;
    localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int STEP_W     = 16;
    localparam int DIV_CNT_W  = $clog2(STEP_W);

    // configuration register indexes
    localparam logic [2:0] CFG_ORDER_FIRST  = 3'd0;
    localparam logic [2:0] CFG_ORDER_SECOND = 3'd1;
    localparam logic [2:0] CFG_ORDER_THIRD  = 3'd2;
    localparam logic [2:0] CFG_ORDER_FOURTH = 3'd3;
    localparam logic [2:0] CFG_PIXEL_COUNT  = 3'd4;
    localparam logic [2:0] CFG_BRIGHTNESS   = 3'd5;
    localparam logic [2:0] CFG_LATCH_BYTES  = 3'd6;

    // request codes
    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_FILL   = 2'd1,
        REQ_SHOW   = 2'd2,
        REQ_ROTATE = 2'd3
    } t_req_type;

    // source channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_WHITE = 2'd3;

    typedef struct packed {
        t_req_type   req_type;
        logic [7:0]  pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  white;
        logic [15:0] rotate_steps;
    } t_in_req;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] wire_byte0;
        logic [7:0] wire_byte1;
        logic [7:0] wire_byte2;
        logic [7:0] wire_byte3;
        logic [7:0] gap_bytes;
        logic       is_last;
    } t_out_item;

    // pick one colour channel by its source code
    function automatic logic [7:0] pick_channel(input logic [1:0] sel, input t_in_req req);
        logic [7:0] res;
        unique case (sel)
            CH_RED:   res = req.red;
            CH_GREEN: res = req.green;
            CH_BLUE:  res = req.blue;
            CH_WHITE: res = req.white;
            default:  res = req.red;
        endcase
        return res;
    endfunction

    // colours into wire order, wire byte k in bits 8k+7..8k
    function automatic logic [31:0] reorder(input t_in_req req, input logic [1:0] s0,
                                            input logic [1:0] s1, input logic [1:0] s2,
                                            input logic [1:0] s3);
        return {pick_channel(s3, req), pick_channel(s2, req),
                pick_channel(s1, req), pick_channel(s0, req)};
    endfunction

endpackage

### src/rgbw_pixel_frame_buffer_core.sv
// RGBW strip frame buffer.
// Input channel (i_in_valid / o_in_ready, i_in_req) takes one request at a time;
// o_in_ready is high only while the sequencer is idle.
// Output channel (o_out_valid / i_out_ready, o_out_item) streams one item per
// pixel in logical order and then a trailer carrying the latch gap, marked last.
// Configuration is a plain write port (i_cfg_wen, i_cfg_idx, i_cfg_data), with
// no wait; writing the pixel count clears the rotation.
// Operations, n being the active pixel count:
//   set pixel: written on acceptance, no output
//   rotate: a 16-step restoring remainder unit plus one add
//   show: n+1 reads on the one store read port, one per cycle unless stalled
//   fill: n writes on the single store write port, then as show at full scale
// The first output of a send passes the read, multiply and output stages;
// all three hold when the receiver stalls, so reads are paused and nothing
// is lost. A new request may be taken while the tail of a send is still
// draining.
// Reset clears the per-pixel valid flags, so the store reads as zero at once
// with no clearing pass, and loads the register reset values.
module rgbw_pixel_frame_buffer_core
    import rpfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_req   i_in_req,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_wen,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SEND,
        ST_DIV,
        ST_ADJ
    } t_state;

    t_state r_state;

    // configuration and rotation
    logic [1:0]        r_order [4];
    logic [5:0]        r_pix_count;
    logic [7:0]        r_bright;
    logic [7:0]        r_latch;
    logic [ADDR_W-1:0] r_rot;

    // sequencer registers
    logic [CNT_W-1:0]     r_cnt;
    logic [ADDR_W-1:0]    r_slot;
    logic [31:0]          r_fill_word;
    logic [7:0]           r_scale;
    logic [STEP_W-1:0]    r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // pixel store
    logic [31:0]           mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_valid;

    // pipeline
    logic        r_v1, r_k1, r_ok1;
    logic [31:0] r_rd;
    logic [7:0]  r_sc1;
    logic        r_v2, r_k2;
    logic [15:0] r_prod [4];
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic [CNT_W-1:0]  n_active;
    logic              accept;
    logic              pipe_en;
    logic [31:0]       in_word;
    logic [7:0]        idx_clamp;
    logic [CNT_W:0]    set_sum;
    logic [ADDR_W-1:0] set_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              s0_valid;
    logic              s0_kind;
    logic [CNT_W:0]    slot_inc;
    logic [ADDR_W-1:0] slot_next;
    logic [CNT_W:0]    div_t;
    logic [CNT_W:0]    div_next;
    logic [CNT_W:0]    adj_sum;
    logic [ADDR_W-1:0] adj_rot;

    // floor(x / 255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

    // active pixel count, zero taken as one and capped at the store depth
    always_comb begin
        if (r_pix_count == 6'd0) begin
            n_active = CNT_W'(1);
        end else if (32'(r_pix_count) > MAX_PIXELS) begin
            n_active = CNT_W'(MAX_PIXELS);
        end else begin
            n_active = CNT_W'(r_pix_count);
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign pipe_en    = !r_out_valid || i_out_ready;
    assign in_word    = reorder(i_in_req, r_order[0], r_order[1], r_order[2], r_order[3]);

    // set pixel address: clamp, then add rotation modulo the count
    always_comb begin
        if (i_in_req.pixel_index >= 8'(n_active)) begin
            idx_clamp = 8'(n_active) - 8'd1;
        end else begin
            idx_clamp = i_in_req.pixel_index;
        end
        set_sum = (CNT_W + 1)'(idx_clamp) + (CNT_W + 1)'(r_rot);
        if (set_sum >= (CNT_W + 1)'(n_active)) begin
            set_addr = ADDR_W'(set_sum - (CNT_W + 1)'(n_active));
        end else begin
            set_addr = ADDR_W'(set_sum);
        end
    end

    // store write port, used by set pixel and by the fill sweep
    always_comb begin
        mem_we  = (accept && i_in_req.req_type == REQ_SET) || (r_state == ST_FILL);
        wr_addr = (r_state == ST_FILL) ? ADDR_W'(r_cnt) : set_addr;
        wr_data = (r_state == ST_FILL) ? r_fill_word : in_word;
    end

    // read issue and slot wrap
    always_comb begin
        s0_valid = (r_state == ST_SEND);
        s0_kind  = (r_cnt == n_active);
        slot_inc = (CNT_W + 1)'(r_slot) + (CNT_W + 1)'(1);
        if (slot_inc == (CNT_W + 1)'(n_active)) begin
            slot_next = '0;
        end else begin
            slot_next = ADDR_W'(slot_inc);
        end
    end

    // one remainder step and the final rotation add
    always_comb begin
        div_t = {r_rem, r_quo[STEP_W-1]};
        if (div_t >= (CNT_W + 1)'(n_active)) begin
            div_next = div_t - (CNT_W + 1)'(n_active);
        end else begin
            div_next = div_t;
        end
        adj_sum = (CNT_W + 1)'(r_rot) + (CNT_W + 1)'(r_rem);
        if (adj_sum >= (CNT_W + 1)'(n_active)) begin
            adj_rot = ADDR_W'(adj_sum - (CNT_W + 1)'(n_active));
        end else begin
            adj_rot = ADDR_W'(adj_sum);
        end
    end

    // sequencer, configuration and rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_order[0]  <= CH_GREEN;
            r_order[1]  <= CH_RED;
            r_order[2]  <= CH_BLUE;
            r_order[3]  <= CH_WHITE;
            r_pix_count <= 6'd32;
            r_bright    <= 8'd255;
            r_latch     <= 8'd0;
            r_rot       <= '0;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_div_cnt   <= '0;
            r_rem       <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_in_req.req_type)
                            REQ_SET: begin
                            end
                            REQ_FILL: begin
                                r_fill_word <= in_word;
                                r_scale     <= 8'd255;
                                r_cnt       <= '0;
                                r_state     <= ST_FILL;
                            end
                            REQ_SHOW: begin
                                r_scale <= r_bright;
                                r_cnt   <= '0;
                                r_slot  <= r_rot;
                                r_state <= ST_SEND;
                            end
                            REQ_ROTATE: begin
                                r_quo     <= i_in_req.rotate_steps;
                                r_rem     <= '0;
                                r_div_cnt <= '0;
                                r_state   <= ST_DIV;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    if (r_cnt == n_active - CNT_W'(1)) begin
                        r_cnt   <= '0;
                        r_slot  <= r_rot;
                        r_state <= ST_SEND;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_SEND: begin
                    if (pipe_en) begin
                        if (s0_kind) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cnt  <= r_cnt + CNT_W'(1);
                            r_slot <= slot_next;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem     <= CNT_W'(div_next);
                    r_quo     <= {r_quo[STEP_W-2:0], 1'b0};
                    r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    if (r_div_cnt == DIV_CNT_W'(STEP_W - 1)) begin
                        r_state <= ST_ADJ;
                    end
                end
                ST_ADJ: begin
                    r_rot   <= adj_rot;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (i_cfg_wen) begin
                unique case (i_cfg_idx)
                    CFG_ORDER_FIRST:  r_order[0] <= i_cfg_data[1:0];
                    CFG_ORDER_SECOND: r_order[1] <= i_cfg_data[1:0];
                    CFG_ORDER_THIRD:  r_order[2] <= i_cfg_data[1:0];
                    CFG_ORDER_FOURTH: r_order[3] <= i_cfg_data[1:0];
                    CFG_PIXEL_COUNT: begin
                        r_pix_count <= i_cfg_data[5:0];
                        r_rot       <= '0;
                    end
                    CFG_BRIGHTNESS:   r_bright <= i_cfg_data;
                    CFG_LATCH_BYTES:  r_latch  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // store memory; reads are registered whenever the pipeline moves, writes occur only outside sending
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (pipe_en) begin
            r_rd <= mem[r_slot];
        end
    end

    // written flags, an unwritten slot reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // read, scale and output stages, all held on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_v1        <= s0_valid;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_k1  <= s0_kind;
            r_ok1 <= r_valid[r_slot];
            r_sc1 <= r_scale;
            r_k2  <= r_k1;
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= (r_ok1 ? {8'd0, r_rd[8*k +: 8]} : 16'd0) * {8'd0, r_sc1};
            end
            r_out_item.item_kind  <= r_k2;
            r_out_item.wire_byte0 <= r_k2 ? 8'd0 : div255(r_prod[0]);
            r_out_item.wire_byte1 <= r_k2 ? 8'd0 : div255(r_prod[1]);
            r_out_item.wire_byte2 <= r_k2 ? 8'd0 : div255(r_prod[2]);
            r_out_item.wire_byte3 <= r_k2 ? 8'd0 : div255(r_prod[3]);
            r_out_item.gap_bytes  <= r_k2 ? r_latch : 8'd0;
            r_out_item.is_last    <= r_k2;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
